// File: rtl/core/deadline_timer_min_heap_macros.svh
// Assertion helpers for the timer queue. They sample on aclk and are
// disabled while aresetn is low.
`ifndef DEADLINE_TIMER_MIN_HEAP_MACROS_SVH
`define DEADLINE_TIMER_MIN_HEAP_MACROS_SVH

// Same-cycle implication
`define DTMH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DTMH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/dtmh_pkg.sv
package dtmh_pkg;

    // Heap geometry
    localparam int DEPTH   = 16;
    localparam int MAX_OUT = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int CHILD_W = ADDR_W + 2;
    localparam int FIRED_W = $clog2(MAX_OUT + 1);

    // Delay arithmetic
    localparam int          SEC_W      = 31;
    localparam int          NSEC_W     = 30;
    localparam int          PROD_W     = SEC_W + NSEC_W;
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [31:0] NSEC_LIMIT = 32'd1000000000;

    // Stream widths
    localparam int S_TDATA_W = 256;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 128;
    localparam int M_TUSER_W = 2;

    // Item kinds
    typedef enum logic [1:0] {
        OP_ARM   = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_TIMED_OUT = 2'd0,
        ST_INVALID   = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // One heap entry
    typedef struct packed {
        logic [63:0] deadline;
        logic [63:0] position;
        logic [63:0] tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/core/dtmh_ram.sv
module dtmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/deadline_timer_min_heap.sv
// Timer queue kept as a binary min-heap of DEPTH entries in one single-port-read
// RAM, walked by a small sequencer; only one item is worked on at a time and
// s_tready is high only while the sequencer is idle. An arm item with a bad
// delay or a full heap gives its single result from S_EMIT once the output
// register is free. A valid arm computes its deadline in S_MUL and S_ADD, then
// climbs from the last slot toward the root through S_UP_RD and S_UP_CMP.
// A tick reads and checks the root; per timer popped it fetches the last entry
// as the new root and sinks it through S_DN_RL, S_DN_RR and S_DN_CMP unless
// the pop empties the heap, with at most MAX_OUT timers per tick. A clear
// resets the entry count and gives no result. Heap storage needs no clearing
// pass after reset. Results leave through an output register, so the sequencer
// keeps working while one result waits on m_tready.
module deadline_timer_min_heap
    import dtmh_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // now_ns[63:0], delay_sec[95:64], delay_nsec[127:96],
    // slot_position[191:128], tag[255:192]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_position[63:0], out_tag[127:64]
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

`include "deadline_timer_min_heap_macros.svh"

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_EMIT    = 13'b0000000000010,
        S_MUL     = 13'b0000000000100,
        S_ADD     = 13'b0000000001000,
        S_UP_RD   = 13'b0000000010000,
        S_UP_CMP  = 13'b0000000100000,
        S_TK_RD   = 13'b0000001000000,
        S_TK_CHK  = 13'b0000010000000,
        S_DN_LAST = 13'b0000100000000,
        S_DN_LOAD = 13'b0001000000000,
        S_DN_RL   = 13'b0010000000000,
        S_DN_RR   = 13'b0100000000000,
        S_DN_CMP  = 13'b1000000000000
    } state_t;

    // Control state
    state_t              state_reg,  state_next;
    logic [COUNT_W-1:0]  count_reg,  count_next;
    logic [FIRED_W-1:0]  fired_reg,  fired_next;
    logic [ADDR_W-1:0]   hole_reg,   hole_next;
    logic                pend_reg,   pend_next;

    // Working registers
    status_t             status_reg, status_next;
    logic [63:0]         now_reg,    now_next;
    logic [SEC_W-1:0]    sec_reg,    sec_next;
    logic [NSEC_W-1:0]   nsec_reg,   nsec_next;
    logic [PROD_W-1:0]   prod_reg,   prod_next;
    entry_t              item_reg,   item_next;
    entry_t              left_reg,   left_next;
    logic [63:0]         res_pos_reg, res_pos_next;
    logic [63:0]         res_tag_reg, res_tag_next;

    // Output register
    logic                m_tvalid_reg;
    status_t             m_status_reg;
    logic [63:0]         m_pos_reg;
    logic [63:0]         m_tag_reg;
    logic                m_tlast_reg;

    // RAM port
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    entry_t              ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    entry_t              ram_rdata;

    // Output load request
    logic                out_free;
    logic                out_load;
    status_t             out_status;
    logic [63:0]         out_pos;
    logic [63:0]         out_tag;
    logic                out_last;

    // Index helpers
    logic [ADDR_W-1:0]   parent_idx;
    logic [CHILD_W-1:0]  left_idx;
    logic [CHILD_W-1:0]  right_idx;
    logic                expire;
    logic                up_move;
    logic                left_lt;
    logic [63:0]         best_dl;
    logic                right_win;
    logic                s_accept;
    logic                arm_bad;

    dtmh_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_heap_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Heap index arithmetic
    assign parent_idx = (hole_reg - 1'b1) >> 1;
    assign left_idx   = CHILD_W'({hole_reg, 1'b1});
    assign right_idx  = left_idx + 1'b1;

    // Compares for the sift steps
    assign expire    = (count_reg != '0) && (fired_reg < FIRED_W'(MAX_OUT))
                       && (ram_rdata.deadline <= now_reg);
    assign up_move   = item_reg.deadline < ram_rdata.deadline;
    assign left_lt   = left_reg.deadline < item_reg.deadline;
    assign best_dl   = left_lt ? left_reg.deadline : item_reg.deadline;
    assign right_win = (right_idx < CHILD_W'(count_reg)) && (ram_rdata.deadline < best_dl);

    assign arm_bad = s_tdata[95] || s_tdata[127] || (s_tdata[127:96] >= NSEC_LIMIT);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        fired_next   = fired_reg;
        hole_next    = hole_reg;
        pend_next    = pend_reg;
        status_next  = status_reg;
        now_next     = now_reg;
        sec_next     = sec_reg;
        nsec_next    = nsec_reg;
        prod_next    = prod_reg;
        item_next    = item_reg;
        left_next    = left_reg;
        res_pos_next = res_pos_reg;
        res_tag_next = res_tag_reg;
        ram_we       = 1'b0;
        ram_waddr    = hole_reg;
        ram_wdata    = item_reg;
        ram_raddr    = '0;
        out_load     = 1'b0;
        out_status   = ST_TIMED_OUT;
        out_pos      = res_pos_reg;
        out_tag      = res_tag_reg;
        out_last     = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    now_next           = s_tdata[63:0];
                    sec_next           = s_tdata[94:64];
                    nsec_next          = s_tdata[125:96];
                    item_next.position = s_tdata[191:128];
                    item_next.tag      = s_tdata[255:192];
                    case (s_tuser)
                        OP_ARM: begin
                            if (arm_bad) begin
                                status_next = ST_INVALID;
                                state_next  = S_EMIT;
                            end else if (count_reg == COUNT_W'(DEPTH)) begin
                                status_next = ST_FULL;
                                state_next  = S_EMIT;
                            end else begin
                                state_next = S_MUL;
                            end
                        end
                        OP_TICK: begin
                            fired_next = '0;
                            pend_next  = 1'b0;
                            state_next = S_TK_RD;
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: ;
                    endcase
                end
            end

            // Rejected arm: one result, last set
            S_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = status_reg;
                    out_pos    = item_reg.position;
                    out_tag    = item_reg.tag;
                    state_next = S_IDLE;
                end
            end

            S_MUL: begin
                prod_next  = sec_reg * NS_PER_SEC;
                state_next = S_ADD;
            end

            S_ADD: begin
                item_next.deadline = now_reg + 64'(prod_reg) + 64'(nsec_reg);
                hole_next          = count_reg[ADDR_W-1:0];
                state_next         = S_UP_RD;
            end

            // Sift up: read the parent of the hole, or settle at the root
            S_UP_RD: begin
                ram_raddr = parent_idx;
                if (hole_reg == '0) begin
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_UP_CMP;
                end
            end

            // Parent moves down into the hole, or the new timer settles
            S_UP_CMP: begin
                ram_raddr = parent_idx;
                ram_we    = 1'b1;
                if (up_move) begin
                    ram_wdata  = ram_rdata;
                    hole_next  = parent_idx;
                    state_next = S_UP_RD;
                end else begin
                    count_next = count_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_TK_RD: begin
                state_next = S_TK_CHK;
            end

            // Root check; a held result goes out once its successor is known
            S_TK_CHK: begin
                if (!(pend_reg && !out_free)) begin
                    if (pend_reg) begin
                        out_load  = 1'b1;
                        out_last  = !expire;
                        pend_next = 1'b0;
                    end
                    if (expire) begin
                        res_pos_next = ram_rdata.position;
                        res_tag_next = ram_rdata.tag;
                        pend_next    = 1'b1;
                        fired_next   = fired_reg + 1'b1;
                        count_next   = count_reg - 1'b1;
                        state_next   = (count_reg == COUNT_W'(1)) ? S_TK_RD : S_DN_LAST;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            // Fetch the last entry, it becomes the root
            S_DN_LAST: begin
                ram_raddr  = count_reg[ADDR_W-1:0];
                state_next = S_DN_LOAD;
            end

            S_DN_LOAD: begin
                item_next  = ram_rdata;
                hole_next  = '0;
                state_next = S_DN_RL;
            end

            // Sift down: read left child, or settle when there is none
            S_DN_RL: begin
                ram_raddr = left_idx[ADDR_W-1:0];
                if (left_idx < CHILD_W'(count_reg)) begin
                    state_next = S_DN_RR;
                end else begin
                    ram_we     = 1'b1;
                    state_next = S_TK_RD;
                end
            end

            S_DN_RR: begin
                left_next  = ram_rdata;
                ram_raddr  = right_idx[ADDR_W-1:0];
                state_next = S_DN_CMP;
            end

            // Smallest of entry, left, right; ties keep the earlier one
            S_DN_CMP: begin
                ram_we = 1'b1;
                if (right_win) begin
                    ram_wdata  = ram_rdata;
                    hole_next  = right_idx[ADDR_W-1:0];
                    state_next = S_DN_RL;
                end else if (left_lt) begin
                    ram_wdata  = left_reg;
                    hole_next  = left_idx[ADDR_W-1:0];
                    state_next = S_DN_RL;
                end else begin
                    state_next = S_TK_RD;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            fired_reg    <= '0;
            hole_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            fired_reg <= fired_next;
            hole_reg  <= hole_next;
            pend_reg  <= pend_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        now_reg     <= now_next;
        sec_reg     <= sec_next;
        nsec_reg    <= nsec_next;
        prod_reg    <= prod_next;
        item_reg    <= item_next;
        left_reg    <= left_next;
        res_pos_reg <= res_pos_next;
        res_tag_reg <= res_tag_next;
        if (out_load) begin
            m_status_reg <= out_status;
            m_pos_reg    <= out_pos;
            m_tag_reg    <= out_tag;
            m_tlast_reg  <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_tag_reg, m_pos_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_tlast_reg;

    // Checks
    `DTMH_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= COUNT_W'(DEPTH), "entry count over depth")
    `DTMH_ASSERT_IMP(a_fired_bound, 1'b1, fired_reg <= FIRED_W'(MAX_OUT), "too many pops in a tick")
    `DTMH_ASSERT_NXT(a_clear_empties, s_accept && s_tuser == OP_CLEAR, count_reg == '0, "clear kept timers")
    `DTMH_ASSERT_NXT(a_arm_grows, state_reg == S_UP_CMP && !up_move, count_reg == $past(count_reg) + 1'b1, "arm did not add one timer")

endmodule

// File: sim/testbench.sv
module testbench;
    import dtmh_pkg::*;

    // Op code that the block must ignore
    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam logic [63:0] NS_IN_SEC     = 64'd1000000000;
    localparam logic [63:0] ALL_ONES      = {64{1'b1}};
    localparam int          RANDOM_ITEMS  = 400;
    localparam int          SETTLE_CYCLES = 400;
    localparam int          DRAIN_LIMIT   = 500000;
    localparam int          REPORT_LIMIT  = 10;

    // How a stimulus row is checked
    typedef enum logic [1:0] {
        CHECK_PREDICTED,
        CHECK_NO_RESULT,
        CHECK_ONE_RESULT
    } row_check_t;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] now_ns;
        logic [31:0] delay_sec;
        logic [31:0] delay_nsec;
        logic [63:0] position;
        logic [63:0] tag;
        row_check_t  check;
        status_t     status;
    } stim_row_t;

    typedef struct {
        status_t     status;
        logic [63:0] position;
        logic [63:0] tag;
        logic        last;
    } completion_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    // Check kind of the item currently on the input channel
    row_check_t item_check = CHECK_PREDICTED;
    status_t    item_status = ST_TIMED_OUT;

    // Predicted heap
    logic [63:0] timer_deadline [DEPTH];
    logic [63:0] timer_position [DEPTH];
    logic [63:0] timer_tag [DEPTH];
    int          pending_timers = 0;

    completion_t predicted_completions[$];
    completion_t awaited_completions[$];
    stim_row_t   directed_rows[$];

    int          fail_count = 0;
    int          burst_left = 0;
    int          arm_pct = 50;
    logic [63:0] timeline_ns = 64'd0;
    int          ready_mode = 0;
    int          ready_hold = 0;

    deadline_timer_min_heap dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Heap predictor
    // ---------------------------------------------------------------
    function automatic void swap_timers(input int a, input int b);
        logic [63:0] t;
        t = timer_deadline[a]; timer_deadline[a] = timer_deadline[b]; timer_deadline[b] = t;
        t = timer_position[a]; timer_position[a] = timer_position[b]; timer_position[b] = t;
        t = timer_tag[a];      timer_tag[a] = timer_tag[b];           timer_tag[b] = t;
    endfunction

    // Climb while strictly earlier than the parent
    function automatic void sift_timer_up(input int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (timer_deadline[i] >= timer_deadline[p])
                break;
            swap_timers(i, p);
            i = p;
        end
    endfunction

    // Sink toward the smaller child, left child wins a tie
    function automatic void sift_timer_down(input int i);
        int l;
        int r;
        int s;
        while (i < pending_timers) begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            s = i;
            if (l < pending_timers && timer_deadline[l] < timer_deadline[s])
                s = l;
            if (r < pending_timers && timer_deadline[r] < timer_deadline[s])
                s = r;
            if (s == i)
                break;
            swap_timers(i, s);
            i = s;
        end
    endfunction

    // Apply one input item; completions land in predicted_completions
    function automatic void predict_timer_queue(input logic [1:0] op, input logic [63:0] now,
                                                input logic [31:0] sec, input logic [31:0] nsec,
                                                input logic [63:0] pos, input logic [63:0] tag);
        completion_t c;
        predicted_completions.delete();
        case (op)
            OP_ARM: begin
                if (sec[31] || nsec[31] || nsec >= NSEC_LIMIT) begin
                    c = '{ST_INVALID, pos, tag, 1'b1};
                    predicted_completions.push_back(c);
                end else if (pending_timers == DEPTH) begin
                    c = '{ST_FULL, pos, tag, 1'b1};
                    predicted_completions.push_back(c);
                end else begin
                    timer_deadline[pending_timers] = now + 64'(sec) * NS_IN_SEC + 64'(nsec);
                    timer_position[pending_timers] = pos;
                    timer_tag[pending_timers] = tag;
                    sift_timer_up(pending_timers);
                    pending_timers++;
                end
            end
            OP_TICK: begin
                while (predicted_completions.size() < MAX_OUT && pending_timers > 0 &&
                       timer_deadline[0] <= now) begin
                    c = '{ST_TIMED_OUT, timer_position[0], timer_tag[0], 1'b0};
                    pending_timers--;
                    if (pending_timers > 0) begin
                        timer_deadline[0] = timer_deadline[pending_timers];
                        timer_position[0] = timer_position[pending_timers];
                        timer_tag[0] = timer_tag[pending_timers];
                        sift_timer_down(0);
                    end
                    predicted_completions.push_back(c);
                end
                if (predicted_completions.size() > 0)
                    predicted_completions[predicted_completions.size() - 1].last = 1'b1;
            end
            OP_CLEAR: begin
                pending_timers = 0;
            end
            default: ;
        endcase
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("mismatch: %s", msg);
    endfunction

    // ---------------------------------------------------------------
    // Monitor: predict on input handshake, check on output handshake
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        completion_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_timer_queue(s_tuser, s_tdata[63:0], s_tdata[95:64], s_tdata[127:96],
                                    s_tdata[191:128], s_tdata[255:192]);
                case (item_check)
                    CHECK_PREDICTED: awaited_completions = {awaited_completions,
                                                            predicted_completions};
                    CHECK_ONE_RESULT: begin
                        want = '{item_status, s_tdata[191:128], s_tdata[255:192], 1'b1};
                        awaited_completions.push_back(want);
                    end
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (awaited_completions.size() == 0) begin
                    note_failure($sformatf("unexpected result status %0d pos %h tag %h last %b",
                                           m_tuser, m_tdata[63:0], m_tdata[127:64], m_tlast));
                end else begin
                    want = awaited_completions.pop_front();
                    if (m_tuser !== want.status)
                        note_failure($sformatf("status exp %0d got %0d", want.status, m_tuser));
                    if (m_tdata[63:0] !== want.position)
                        note_failure($sformatf("position exp %h got %h",
                                               want.position, m_tdata[63:0]));
                    if (m_tdata[127:64] !== want.tag)
                        note_failure($sformatf("tag exp %h got %h", want.tag, m_tdata[127:64]));
                    if (m_tlast !== want.last)
                        note_failure($sformatf("last exp %b got %b", want.last, m_tlast));
                end
            end
        end
    end

    // Receiver: stall mode is redrawn each time its hold counter runs out
    always @(posedge aclk) begin
        if (ready_hold == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_hold <= $urandom_range(40, 160);
        end else begin
            ready_hold <= ready_hold - 1;
        end
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= (ready_hold % 8 != 0);
        endcase
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic stim_row_t make_row(input logic [1:0] op, input logic [63:0] now,
                                           input logic [31:0] sec, input logic [31:0] nsec,
                                           input logic [63:0] pos, input logic [63:0] tag,
                                           input row_check_t check,
                                           input status_t status = ST_TIMED_OUT);
        stim_row_t r;
        r = '{op, now, sec, nsec, pos, tag, check, status};
        return r;
    endfunction

    function automatic void load_directed_table();
        int i;
        // empty heap, bad delays, wrap, op that is ignored
        directed_rows.push_back(make_row(OP_TICK, 64'd0, 0, 0, 0, 0, CHECK_NO_RESULT));
        directed_rows.push_back(make_row(OP_ARM, 64'd0, 32'h8000_0000, 0, 64'd0, ALL_ONES,
                                         CHECK_ONE_RESULT, ST_INVALID));
        directed_rows.push_back(make_row(OP_ARM, 64'd0, 0, 32'hFFFF_FFFF, ALL_ONES, 64'd0,
                                         CHECK_ONE_RESULT, ST_INVALID));
        directed_rows.push_back(make_row(OP_ARM, ALL_ONES, 32'h7FFF_FFFF, NSEC_LIMIT,
                                         64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                                         CHECK_ONE_RESULT, ST_INVALID));
        directed_rows.push_back(make_row(OP_ARM, ALL_ONES, 32'h7FFF_FFFF, 32'd999999999,
                                         64'hA1, 64'hB1, CHECK_NO_RESULT));
        directed_rows.push_back(make_row(OP_ARM, 64'd0, 0, 32'd999999999, 64'hA2, 64'hB2,
                                         CHECK_NO_RESULT));
        directed_rows.push_back(make_row(OP_UNUSED, ALL_ONES, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                         ALL_ONES, ALL_ONES, CHECK_NO_RESULT));
        // deadline exactly equal to now fires
        directed_rows.push_back(make_row(OP_TICK, 64'd999999999, 0, 0, 0, 0, CHECK_PREDICTED));
        directed_rows.push_back(make_row(OP_CLEAR, 0, 0, 0, 0, 0, CHECK_NO_RESULT));
        directed_rows.push_back(make_row(OP_TICK, ALL_ONES, 0, 0, 0, 0, CHECK_NO_RESULT));
        // fill with falling deadlines in tied pairs, then overflow
        for (i = 0; i < DEPTH; i++)
            directed_rows.push_back(make_row(OP_ARM, 64'd1000, 0, 32'((DEPTH - 1 - i) / 2),
                                             64'(i), ~64'(i), CHECK_NO_RESULT));
        directed_rows.push_back(make_row(OP_ARM, 64'd1000, 1, 0, 64'hF0, 64'hF1,
                                         CHECK_ONE_RESULT, ST_FULL));
        // drain the full heap in one tick
        directed_rows.push_back(make_row(OP_TICK, ALL_ONES, 0, 0, 0, 0, CHECK_PREDICTED));
    endfunction

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly well-formed arms and ticks on a running clock, some noise
    function automatic stim_row_t random_row();
        stim_row_t r;
        logic [31:0] sec;
        r = make_row(OP_ARM, timeline_ns, 0, 0, random_word(), random_word(), CHECK_PREDICTED);
        if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    r.delay_sec = $urandom;
                    r.delay_nsec = $urandom;
                end
                2: begin
                    r.now_ns = random_word();
                    r.delay_sec = $urandom & 32'h7FFF_FFFF;
                    r.delay_nsec = $urandom_range(0, 999999999);
                end
                3: begin
                    r.op = OP_TICK;
                    r.now_ns = random_word();
                end
                4: begin
                    r.op = OP_UNUSED;
                    r.now_ns = random_word();
                    r.delay_sec = $urandom;
                    r.delay_nsec = $urandom;
                end
                default: r.op = OP_CLEAR;
            endcase
        end else if ($urandom_range(0, 99) < arm_pct) begin
            sec = $urandom_range(0, 2);
            if ($urandom_range(0, 15) == 0)
                sec = $urandom_range(0, 32'h7FFF_FFFF);
            r.delay_sec = sec;
            r.delay_nsec = $urandom_range(0, 999999999);
        end else begin
            timeline_ns = timeline_ns + 64'($urandom_range(0, 1200000000));
            r.op = OP_TICK;
            r.now_ns = timeline_ns;
        end
        return r;
    endfunction

    // Present one item, hold until taken, then maybe idle
    task automatic send_item(input stim_row_t r);
        s_tvalid <= 1'b1;
        s_tuser <= r.op;
        s_tdata <= {r.tag, r.position, r.delay_nsec, r.delay_sec, r.now_ns};
        item_check <= r.check;
        item_status <= r.status;
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 8);
        end
    endtask

    initial begin
        int sent;
        int waited;
        bit paused;
        stim_row_t r;
        sent = 0;
        paused = 1'b0;
        load_directed_table();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        // random part
        while (sent < RANDOM_ITEMS) begin
            if (sent % 50 == 0)
                arm_pct = 25 * $urandom_range(1, 3);
            r = random_row();
            send_item(r);
            if (r.op != OP_UNUSED)
                sent++;
            // hold off once until every pending completion is out
            if (sent == RANDOM_ITEMS / 2 && !paused) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                // let the monitor book the last accepted item first
                @(posedge aclk);
                while (awaited_completions.size() != 0)
                    @(posedge aclk);
            end
        end

        // wind down
        s_tvalid <= 1'b0;
        @(posedge aclk);
        for (waited = 0; awaited_completions.size() != 0 && waited < DRAIN_LIMIT; waited++)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (awaited_completions.size() != 0)
            note_failure($sformatf("%0d results never arrived", awaited_completions.size()));
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop
    initial begin
        #8000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/dtmh_pkg.sv
rtl/core/dtmh_ram.sv
rtl/core/deadline_timer_min_heap.sv
sim/testbench.sv
